@@ sv/sv39ptm_pkg.sv @@
// Shared types, constants and entry encoding helpers for the Sv39 page table manager.
`default_nettype none
package sv39ptm_pkg;

  localparam int TABLE_PAGES_DEF = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;
  localparam int CNT_W = 10;
  localparam int PPN_W = 44;

  localparam logic [1:0] MODE_MAP = 2'd0;
  localparam logic [1:0] MODE_UNMAP = 2'd1;
  localparam logic [1:0] MODE_PROTECT = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  localparam logic [1:0] LVL_TWO = 2'd2;
  localparam logic [1:0] LVL_ONE = 2'd1;
  localparam logic [1:0] LVL_ZERO = 2'd0;

  localparam logic [1:0] PBMT_NC = 2'd1;
  localparam logic [1:0] PBMT_IO = 2'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR_STEP,
    OP_PSWEEP_INIT,
    OP_PSWEEP_STEP,
    OP_DESCEND,
    OP_LEAF,
    OP_SCAN_INIT,
    OP_SCAN_NEXT,
    OP_TAKE,
    OP_LINK,
    OP_WRITE,
    OP_FREE_L1,
    OP_FREE_L2,
    OP_RES_BAD,
    OP_RES_MISS,
    OP_RES_OK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       root_bad;
    logic       pa_zero;
    logic [1:0] mode;
    logic [1:0] lvl;
    logic       q_valid;
    logic       q_child_ok;
    logic       scan_found;
    logic       scan_last;
    logic       cnt_nonzero;
    logic       clr_full_last;
    logic       clr_page_last;
    logic       write_zero;
  } dp_status_t;

  function automatic logic [63:0] encode_flags(input logic [6:0] at);
    logic [63:0] f;
    f = 64'h0;
    f[0] = 1'b1;
    f[1] = at[0];
    f[2] = at[1];
    f[3] = at[2];
    f[4] = at[3];
    f[5] = at[4];
    f[6] = 1'b1;
    f[7] = 1'b1;
    if (at[5]) begin
      f[62:61] = PBMT_IO;
    end else if (at[6]) begin
      f[62:61] = PBMT_NC;
    end
    return f;
  endfunction

  function automatic logic [6:0] decode_flags(input logic [63:0] e);
    logic [6:0] at;
    at = 7'h0;
    at[0] = e[1];
    at[1] = e[2];
    at[2] = e[3];
    at[3] = e[4];
    at[4] = e[5];
    if (e[62:61] == PBMT_IO) begin
      at[5] = 1'b1;
    end else if (e[62:61] == PBMT_NC) begin
      at[6] = 1'b1;
    end
    return at;
  endfunction

endpackage
`default_nettype wire

@@ sv/sv39ptm_datapath.sv @@
// Datapath of the Sv39 page table manager: table store, pool state, walk registers and result.
`default_nettype none
module sv39ptm_datapath #(
  parameter int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sv39ptm_pkg::dp_cmd_t   cmd,
  output sv39ptm_pkg::dp_status_t     status,
  input  wire logic                   cfg_write_enable,
  input  wire logic [5:0]             cfg_write_data,
  input  wire logic [1:0]             in_mode,
  input  wire logic [26:0]            in_virtual_page,
  input  wire logic [55:0]            in_physical_address,
  input  wire logic [6:0]             in_attributes,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [55:0]                 out_found_address,
  output logic [6:0]                  out_found_attributes,
  output logic [62:0]                 out_leaf_entry
);

  localparam int PW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int IW = sv39ptm_pkg::IDX_W;
  localparam int AW = PW + IW;
  localparam int DEPTH = TABLE_PAGES * sv39ptm_pkg::ENTRIES_PER_TABLE;
  localparam int CW = sv39ptm_pkg::CNT_W;

  logic [63:0] tbl_mem [DEPTH];
  logic [CW-1:0] cnt_mem [TABLE_PAGES];
  logic use_mem [TABLE_PAGES];

  logic [63:0]   tbl_q;
  logic [CW-1:0] cnt_q;
  logic          use_q;

  logic [5:0]    root_cfg_r;
  logic [1:0]    mode_r;
  logic [26:0]   vp_r;
  logic [55:0]   pa_r;
  logic [6:0]    at_r;
  logic [PW-1:0] root_pg_r;
  logic          root_bad_r;
  logic [1:0]    lvl_r;
  logic [PW-1:0] pg1_r;
  logic [PW-1:0] a_pg_r;
  logic [IW-1:0] a_ix_r;
  logic [63:0]   wval_r;
  logic [63:0]   e_r;
  logic [PW-1:0] scan_r;
  logic [AW-1:0] clr_r;
  logic          wz_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [55:0]   out_found_address_r;
  logic [6:0]    out_found_attributes_r;
  logic [62:0]   out_leaf_entry_r;

  logic          tbl_we;
  logic [AW-1:0] tbl_wa;
  logic [63:0]   tbl_wd;
  logic          cnt_we;
  logic [PW-1:0] cnt_wa;
  logic [CW-1:0] cnt_wd;
  logic          use_we;
  logic [PW-1:0] use_wa;
  logic          use_wd;
  logic [CW-1:0] cnt_new;
  logic [PW-1:0] child_pg;
  logic [63:0]   leaf_map;
  logic [63:0]   leaf_prot;

  assign child_pg = tbl_q[10 +: PW];
  assign leaf_map = {10'b0, pa_r[55:12], 10'b0} | sv39ptm_pkg::encode_flags(at_r);
  assign leaf_prot = {10'b0, tbl_q[53:10], 10'b0} | sv39ptm_pkg::encode_flags(at_r);

  always_comb begin
    if (tbl_q[0] && !wval_r[0] && (cnt_q != '0)) begin
      cnt_new = cnt_q - CW'(1);
    end else if (!tbl_q[0] && wval_r[0]) begin
      cnt_new = cnt_q + CW'(1);
    end else begin
      cnt_new = cnt_q;
    end
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = {a_pg_r, a_ix_r};
    tbl_wd = wval_r;
    cnt_we = 1'b0;
    cnt_wa = a_pg_r;
    cnt_wd = cnt_new;
    use_we = 1'b0;
    use_wa = a_pg_r;
    use_wd = 1'b0;
    case (cmd.op)
      sv39ptm_pkg::OP_CLR_STEP: begin
        tbl_we = 1'b1;
        tbl_wa = clr_r;
        tbl_wd = 64'h0;
        cnt_we = 1'b1;
        cnt_wa = clr_r[AW-1:IW];
        cnt_wd = '0;
        use_we = 1'b1;
        use_wa = clr_r[AW-1:IW];
      end
      sv39ptm_pkg::OP_PSWEEP_STEP: begin
        tbl_we = 1'b1;
        tbl_wa = clr_r;
        tbl_wd = 64'h0;
        cnt_we = 1'b1;
        cnt_wd = '0;
      end
      sv39ptm_pkg::OP_WRITE: begin
        tbl_we = 1'b1;
        cnt_we = 1'b1;
      end
      sv39ptm_pkg::OP_TAKE: begin
        use_we = 1'b1;
        use_wa = scan_r;
        use_wd = 1'b1;
      end
      sv39ptm_pkg::OP_FREE_L1, sv39ptm_pkg::OP_FREE_L2: begin
        use_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_mem[{a_pg_r, a_ix_r}];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[a_pg_r];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_q <= use_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_cfg_r <= 6'd0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_write_enable) begin
        root_cfg_r <= cfg_write_data;
      end
      case (cmd.op)
        sv39ptm_pkg::OP_CLR_STEP, sv39ptm_pkg::OP_PSWEEP_STEP: begin
          clr_r <= clr_r + AW'(1);
        end
        sv39ptm_pkg::OP_PSWEEP_INIT: begin
          clr_r <= {scan_r, {IW{1'b0}}};
        end
        sv39ptm_pkg::OP_RES_BAD, sv39ptm_pkg::OP_RES_MISS, sv39ptm_pkg::OP_RES_OK: begin
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sv39ptm_pkg::OP_LOAD: begin
        mode_r <= in_mode;
        vp_r <= in_virtual_page;
        pa_r <= in_physical_address;
        at_r <= in_attributes;
        root_pg_r <= PW'(root_cfg_r);
        root_bad_r <= 32'(root_cfg_r) >= 32'(TABLE_PAGES);
        lvl_r <= sv39ptm_pkg::LVL_TWO;
        a_pg_r <= PW'(root_cfg_r);
        a_ix_r <= in_virtual_page[26:18];
      end
      sv39ptm_pkg::OP_DESCEND: begin
        a_pg_r <= child_pg;
        if (lvl_r == sv39ptm_pkg::LVL_TWO) begin
          pg1_r <= child_pg;
          a_ix_r <= vp_r[17:9];
          lvl_r <= sv39ptm_pkg::LVL_ONE;
        end else begin
          a_ix_r <= vp_r[8:0];
          lvl_r <= sv39ptm_pkg::LVL_ZERO;
          wval_r <= leaf_map;
        end
      end
      sv39ptm_pkg::OP_LEAF: begin
        e_r <= tbl_q;
        wval_r <= (mode_r == sv39ptm_pkg::MODE_PROTECT) ? leaf_prot : 64'h0;
      end
      sv39ptm_pkg::OP_SCAN_INIT: begin
        scan_r <= '0;
      end
      sv39ptm_pkg::OP_SCAN_NEXT: begin
        scan_r <= scan_r + PW'(1);
      end
      sv39ptm_pkg::OP_TAKE: begin
        a_pg_r <= scan_r;
      end
      sv39ptm_pkg::OP_LINK: begin
        if (lvl_r == sv39ptm_pkg::LVL_TWO) begin
          a_pg_r <= root_pg_r;
          a_ix_r <= vp_r[26:18];
        end else begin
          a_pg_r <= pg1_r;
          a_ix_r <= vp_r[17:9];
        end
        wval_r <= (64'(scan_r) << 10) | 64'h1;
      end
      sv39ptm_pkg::OP_WRITE: begin
        wz_r <= (cnt_new == '0);
      end
      sv39ptm_pkg::OP_FREE_L1: begin
        a_pg_r <= pg1_r;
        a_ix_r <= vp_r[17:9];
        wval_r <= 64'h0;
      end
      sv39ptm_pkg::OP_FREE_L2: begin
        a_pg_r <= root_pg_r;
        a_ix_r <= vp_r[26:18];
        wval_r <= 64'h0;
      end
      sv39ptm_pkg::OP_RES_BAD, sv39ptm_pkg::OP_RES_MISS: begin
        out_status_r <= (cmd.op == sv39ptm_pkg::OP_RES_BAD) ?
                        sv39ptm_pkg::ST_BAD_ARG : sv39ptm_pkg::ST_MISSING;
        out_found_address_r <= 56'h0;
        out_found_attributes_r <= 7'h0;
        out_leaf_entry_r <= 63'h0;
      end
      sv39ptm_pkg::OP_RES_OK: begin
        out_status_r <= sv39ptm_pkg::ST_OK;
        out_found_address_r <= 56'h0;
        out_found_attributes_r <= 7'h0;
        out_leaf_entry_r <= wval_r[62:0];
        if (mode_r == sv39ptm_pkg::MODE_UNMAP || mode_r == sv39ptm_pkg::MODE_QUERY) begin
          out_found_address_r <= {e_r[53:10], 12'h0};
          out_leaf_entry_r <= e_r[62:0];
        end
        if (mode_r == sv39ptm_pkg::MODE_QUERY) begin
          out_found_attributes_r <= sv39ptm_pkg::decode_flags(e_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.root_bad = root_bad_r;
    status.pa_zero = (pa_r == 56'h0);
    status.mode = mode_r;
    status.lvl = lvl_r;
    status.q_valid = tbl_q[0];
    status.q_child_ok = tbl_q[0] && (tbl_q[53:10] < sv39ptm_pkg::PPN_W'(TABLE_PAGES));
    status.scan_found = (scan_r != root_pg_r) && !use_q;
    status.scan_last = (scan_r == PW'(TABLE_PAGES - 1));
    status.cnt_nonzero = (cnt_q != '0);
    status.clr_full_last = (clr_r == AW'(DEPTH - 1));
    status.clr_page_last = &clr_r[IW-1:0];
    status.write_zero = wz_r;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_found_address = out_found_address_r;
  assign out_found_attributes = out_found_attributes_r;
  assign out_leaf_entry = out_leaf_entry_r;

endmodule
`default_nettype wire

@@ sv/sv39ptm_controller.sv @@
// Sequencer of the Sv39 page table manager: walk, allocation, entry update and release steps.
`default_nettype none
module sv39ptm_controller (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire sv39ptm_pkg::dp_status_t status,
  output sv39ptm_pkg::dp_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RWAIT,
    S_RCHK,
    S_SWAIT,
    S_SCHK,
    S_CWAIT,
    S_CCHK,
    S_PSWEEP,
    S_PARENT,
    S_WA,
    S_WB,
    S_UN0,
    S_UN1,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   busy_r;
  logic   is_map;

  assign is_map = (status.mode == sv39ptm_pkg::MODE_MAP);

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    cmd.op = sv39ptm_pkg::OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = sv39ptm_pkg::OP_CLR_STEP;
        if (status.clr_full_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = sv39ptm_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.root_bad || (is_map && status.pa_zero)) begin
          cmd.op = sv39ptm_pkg::OP_RES_BAD;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_RWAIT: begin
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (status.lvl == sv39ptm_pkg::LVL_ZERO) begin
          if (!status.q_valid) begin
            cmd.op = sv39ptm_pkg::OP_RES_MISS;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = sv39ptm_pkg::OP_LEAF;
            unique case (status.mode)
              sv39ptm_pkg::MODE_PROTECT: begin
                ret_nxt = S_FIN;
                state_nxt = S_WA;
              end
              sv39ptm_pkg::MODE_UNMAP: begin
                ret_nxt = S_UN0;
                state_nxt = S_WA;
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end else if (status.q_valid) begin
          if (!status.q_child_ok) begin
            cmd.op = sv39ptm_pkg::OP_RES_MISS;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = sv39ptm_pkg::OP_DESCEND;
            if (is_map && status.lvl == sv39ptm_pkg::LVL_ONE) begin
              ret_nxt = S_FIN;
              state_nxt = S_WA;
            end else begin
              state_nxt = S_RWAIT;
            end
          end
        end else if (is_map) begin
          cmd.op = sv39ptm_pkg::OP_SCAN_INIT;
          state_nxt = S_SWAIT;
        end else begin
          cmd.op = sv39ptm_pkg::OP_RES_MISS;
          state_nxt = S_IDLE;
        end
      end
      S_SWAIT: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (status.scan_found) begin
          cmd.op = sv39ptm_pkg::OP_TAKE;
          state_nxt = S_CWAIT;
        end else if (status.scan_last) begin
          cmd.op = sv39ptm_pkg::OP_RES_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = sv39ptm_pkg::OP_SCAN_NEXT;
          state_nxt = S_SWAIT;
        end
      end
      S_CWAIT: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (status.cnt_nonzero) begin
          cmd.op = sv39ptm_pkg::OP_PSWEEP_INIT;
          state_nxt = S_PSWEEP;
        end else begin
          state_nxt = S_PARENT;
        end
      end
      S_PSWEEP: begin
        cmd.op = sv39ptm_pkg::OP_PSWEEP_STEP;
        if (status.clr_page_last) begin
          state_nxt = S_PARENT;
        end
      end
      S_PARENT: begin
        cmd.op = sv39ptm_pkg::OP_LINK;
        ret_nxt = S_RWAIT;
        state_nxt = S_WA;
      end
      S_WA: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.op = sv39ptm_pkg::OP_WRITE;
        state_nxt = ret_r;
      end
      S_UN0: begin
        if (status.write_zero) begin
          cmd.op = sv39ptm_pkg::OP_FREE_L1;
          ret_nxt = S_UN1;
          state_nxt = S_WA;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UN1: begin
        if (status.write_zero) begin
          cmd.op = sv39ptm_pkg::OP_FREE_L2;
          ret_nxt = S_FIN;
          state_nxt = S_WA;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op = sv39ptm_pkg::OP_RES_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r <= S_FIN;
      busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      busy_r <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

@@ sv/sv39_page_table_manager.sv @@
// Top level of the Sv39 page table manager: controller and datapath.
// An item is taken when start is high and busy is low. Its single result appears on the out_
// ports for one cycle with out_valid high, in the first cycle in which busy is low again, and
// must be taken then, as there is no back-pressure. All table entries live in one table memory
// with a registered read, so the data of each table read is checked only in a later state.
// A map whose tables exist writes the leaf directly; for each missing table it scans the pool
// for a free page and clears that page first when it still holds entries (a former root). An
// unmap releases the level-0 table when it becomes empty, and also the level-1 table when it
// too becomes empty. A bad argument is reported without a walk. After reset a clearing pass
// over all TABLE_PAGES*512 entries runs with busy high.
`default_nettype none
module sv39_page_table_manager #(
  parameter int TABLE_PAGES = sv39ptm_pkg::TABLE_PAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_enable,
  input  wire logic [5:0]  cfg_write_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [26:0] in_virtual_page,
  input  wire logic [55:0] in_physical_address,
  input  wire logic [6:0]  in_attributes,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [55:0]      out_found_address,
  output logic [6:0]       out_found_attributes,
  output logic [62:0]      out_leaf_entry
);

  sv39ptm_pkg::dp_cmd_t    cmd;
  sv39ptm_pkg::dp_status_t status;

  sv39ptm_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  sv39ptm_datapath #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_write_enable     (cfg_write_enable),
    .cfg_write_data       (cfg_write_data),
    .in_mode              (in_mode),
    .in_virtual_page      (in_virtual_page),
    .in_physical_address  (in_physical_address),
    .in_attributes        (in_attributes),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_found_address    (out_found_address),
    .out_found_attributes (out_found_attributes),
    .out_leaf_entry       (out_leaf_entry)
  );

endmodule
`default_nettype wire
